/* hdl/ase_pkg.sv */
package ase_pkg;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  typedef struct packed {
    logic signed [31:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value_res;
    logic               last_res;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    in_item_t item;
    logic     keep;
  } q_entry_t;

  typedef enum logic [7:0] {
    S_LOAD      = 8'b0000_0001,
    S_SORT_I    = 8'b0000_0010,
    S_SORT_HEAD = 8'b0000_0100,
    S_SCAN      = 8'b0000_1000,
    S_SORT_TAIL = 8'b0001_0000,
    S_EMIT_RD   = 8'b0010_0000,
    S_EMIT_LD   = 8'b0100_0000,
    S_EMIT_WAIT = 8'b1000_0000
  } back_state_t;

endpackage

/* hdl/ase_front.sv */
module ase_front #(
  parameter int unsigned DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  ase_pkg::in_item_t item,
  input  logic              q_full,
  output logic              push,
  output ase_pkg::q_entry_t push_entry
);
  import ase_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count;
  logic          keep;

  assign keep             = count < CW'(DEPTH);
  assign item_ready       = !q_full;
  assign push             = item_valid && item_ready;
  assign push_entry.item  = item;
  assign push_entry.keep  = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      if (item.last) begin
        count <= '0;
      end else if (keep) begin
        count <= count + CW'(1);
      end
    end
  end

endmodule

/* hdl/ase_queue.sv */
module ase_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ase_pkg::q_entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output ase_pkg::q_entry_t pop_entry
);
  import ase_pkg::*;

  q_entry_t         entries [QDEPTH];
  logic [QAW-1:0]   wr_ptr;
  logic [QAW-1:0]   rd_ptr;
  logic [QAW:0]     fill;

  assign full      = fill == (QAW + 1)'(QDEPTH);
  assign q_valid   = fill != '0;
  assign pop_entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      if (push && !pop) begin
        fill <= fill + (QAW + 1)'(1);
      end else if (pop && !push) begin
        fill <= fill - (QAW + 1)'(1);
      end
    end
  end

endmodule

/* hdl/ase_back.sv */
module ase_back #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  ase_pkg::q_entry_t  pop_entry,
  output logic               pop,
  output logic               result_valid,
  input  logic               result_ready,
  output ase_pkg::out_item_t result
);
  import ase_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = $clog2(DEPTH);

  logic signed [31:0] mem [DEPTH];
  logic signed [31:0] rdata;

  back_state_t        state;
  logic [CW-1:0]      count;
  logic [CW-1:0]      n;
  logic               dropped;
  logic [AW-1:0]      i;
  logic [CW-1:0]      j;
  logic [AW-1:0]      jr;
  logic [CW-1:0]      k;
  logic signed [31:0] cur;

  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;
  logic [AW-1:0]      ra;
  logic [CW-1:0]      count_next;
  logic               less;

  assign pop        = (state == S_LOAD) && q_valid;
  assign count_next = count + CW'(pop_entry.keep);
  assign less       = rdata < cur;

  always_comb begin
    we = 1'b0;
    wa = jr;
    wd = cur;
    ra = j[AW-1:0];
    unique case (state)
      S_LOAD: begin
        if (pop && pop_entry.keep) begin
          we = 1'b1;
          wa = count[AW-1:0];
          wd = pop_entry.item.value;
        end
      end
      S_SORT_I:    ra = i;
      S_SORT_HEAD: ra = j[AW-1:0];
      S_SCAN: begin
        we = less;
        wa = jr;
        wd = cur;
        ra = j[AW-1:0];
      end
      S_SORT_TAIL: begin
        we = 1'b1;
        wa = i;
        wd = cur;
      end
      S_EMIT_RD:   ra = k[AW-1:0];
      S_EMIT_LD:   ra = k[AW-1:0];
      S_EMIT_WAIT: ra = k[AW-1:0];
      default:     ra = j[AW-1:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      count        <= '0;
      dropped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (pop) begin
            dropped <= dropped | !pop_entry.keep;
            if (pop_entry.item.last) begin
              n     <= count_next;
              count <= '0;
              i     <= '0;
              k     <= '0;
              if (count_next >= CW'(2)) begin
                state <= S_SORT_I;
              end else begin
                state <= S_EMIT_RD;
              end
            end else begin
              count <= count_next;
            end
          end
        end
        S_SORT_I: begin
          j     <= CW'(i) + CW'(1);
          state <= S_SORT_HEAD;
        end
        S_SORT_HEAD: begin
          cur   <= rdata;
          jr    <= j[AW-1:0];
          j     <= j + CW'(1);
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (less) begin
            cur <= rdata;
          end
          if (j < n) begin
            jr <= j[AW-1:0];
            j  <= j + CW'(1);
          end else begin
            state <= S_SORT_TAIL;
          end
        end
        S_SORT_TAIL: begin
          if (CW'(i) + CW'(2) < n) begin
            i     <= i + AW'(1);
            state <= S_SORT_I;
          end else begin
            k     <= '0;
            state <= S_EMIT_RD;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          result.value_res <= rdata;
          result.last_res  <= (k + CW'(1)) == n;
          result.overflow  <= dropped;
          result_valid     <= 1'b1;
          state            <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (result_ready) begin
            result_valid <= 1'b0;
            if ((k + CW'(1)) == n) begin
              dropped <= 1'b0;
              state   <= S_LOAD;
            end else begin
              k     <= k + CW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state        <= S_LOAD;
          result_valid <= 1'b0;
        end
      endcase
    end
  end

endmodule

/* hdl/ascending_sort_engine.sv */
// Collects a list of signed 32-bit values, one request per cycle while the
// queue has room, and returns them in ascending order with the final result
// marked last. Requests pass through a four-entry queue into a single store
// of DEPTH entries. Once the list closes, the store is sorted by exchange
// sort with one compare per cycle on its single read and write port; each
// result is then read from the store, registered and held until taken.
// Elements beyond DEPTH are dropped and every result of that list carries
// the overflow flag. New requests are queued while a list is being sorted
// or sent, until the queue fills.
module ascending_sort_engine #(
  parameter int unsigned DEPTH = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  ase_pkg::in_item_t  item,
  output logic               result_valid,
  input  logic               result_ready,
  output ase_pkg::out_item_t result
);
  import ase_pkg::*;

  logic     q_full;
  logic     push;
  q_entry_t push_entry;
  logic     pop;
  logic     q_valid;
  q_entry_t pop_entry;

  ase_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ase_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry)
  );

  ase_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* verif/tb_ascending_sort_engine.sv */
module tb_ascending_sort_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import ase_pkg::*;

  localparam int unsigned SORT_DEPTH = 32;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;
  localparam int MAX_REPORTS = 10;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 50;

  typedef enum int {
    MIX_FULL,
    MIX_NARROW,
    MIX_EDGE
  } value_mix_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      item_valid = 1'b0;
  logic      item_ready;
  in_item_t  item = '0;
  logic      result_valid;
  logic      result_ready = 1'b0;
  out_item_t result;

  out_item_t          expected_results[$];
  logic signed [31:0] open_list[$];
  logic signed [31:0] staged_values[$];
  logic               open_list_dropped = 1'b0;

  int fail_count = 0;
  int requests_sent = 0;
  int lists_closed = 0;
  int results_seen = 0;
  int overflow_lists = 0;
  int longest_list = 0;
  int rx_hold_cycles = 0;
  bit rx_stalls_on = 1'b1;
  bit tx_gaps_on = 1'b1;

  ascending_sort_engine #(
    .DEPTH(SORT_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic signed [31:0] pick_value(value_mix_t mix);
    logic signed [31:0] v;
    case (mix)
      MIX_NARROW: begin
        v = $signed($urandom_range(0, 8)) - 32'sd4;
      end
      MIX_EDGE: begin
        case ($urandom_range(0, 6))
          0: v = VAL_MIN;
          1: v = VAL_MIN + 32'sd1;
          2: v = -32'sd1;
          3: v = 32'sd0;
          4: v = 32'sd1;
          5: v = VAL_MAX - 32'sd1;
          default: v = VAL_MAX;
        endcase
      end
      default: begin
        v = $urandom();
      end
    endcase
    return v;
  endfunction

  function automatic void absorb_request(in_item_t req);
    logic signed [31:0] sorted[$];
    logic signed [31:0] swap;
    out_item_t          res;
    if (open_list.size() < SORT_DEPTH) begin
      open_list.push_back(req.value);
    end else begin
      open_list_dropped = 1'b1;
    end
    if (!req.last) return;
    sorted = open_list;
    for (int i = 0; i + 1 < sorted.size(); i++) begin
      for (int j = i + 1; j < sorted.size(); j++) begin
        if (sorted[j] < sorted[i]) begin
          swap = sorted[j];
          sorted[j] = sorted[i];
          sorted[i] = swap;
        end
      end
    end
    for (int k = 0; k < sorted.size(); k++) begin
      res.value_res = sorted[k];
      res.last_res  = (k == sorted.size() - 1);
      res.overflow  = open_list_dropped;
      expected_results.push_back(res);
    end
    lists_closed++;
    if (open_list_dropped) overflow_lists++;
    if (sorted.size() > longest_list) longest_list = sorted.size();
    open_list.delete();
    open_list_dropped = 1'b0;
  endfunction

  task automatic send_request(input logic signed [31:0] elem, input logic closes);
    in_item_t req;
    int       gap;
    req.value = elem;
    req.last  = closes;
    gap = tx_gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item_valid <= 1'b1;
    item       <= req;
    do @(posedge clk); while (!item_ready);
    absorb_request(req);
    requests_sent++;
  endtask

  task automatic send_staged_list();
    int n;
    n = staged_values.size();
    for (int k = 0; k < n; k++) begin
      send_request(staged_values[k], k == n - 1);
    end
    staged_values.delete();
  endtask

  task automatic stage_random_list(input int len, input value_mix_t mix);
    for (int k = 0; k < len; k++) begin
      staged_values.push_back(pick_value(mix));
    end
  endtask

  task automatic test_single_element();
    staged_values.push_back(32'sd0);
    send_staged_list();
    staged_values.push_back(VAL_MIN);
    send_staged_list();
    staged_values.push_back(VAL_MAX);
    send_staged_list();
  endtask

  task automatic test_extreme_values();
    staged_values = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1,
                      VAL_MIN + 32'sd1, VAL_MAX - 32'sd1};
    send_staged_list();
  endtask

  task automatic test_equal_values();
    staged_values = '{32'sd3, -32'sd3, 32'sd3, -32'sd3, 32'sd3};
    send_staged_list();
  endtask

  task automatic test_full_store();
    for (int k = 0; k < SORT_DEPTH; k++) begin
      staged_values.push_back(32'sd1000 - 32'sd37 * k);
    end
    send_staged_list();
  endtask

  task automatic test_overflow();
    stage_random_list(SORT_DEPTH + 3, MIX_FULL);
    send_staged_list();
  endtask

  // The sink is held off long enough for the input queue to fill behind a
  // sorted list whose results cannot leave.
  task automatic test_backpressure();
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 300;
    for (int l = 0; l < 3; l++) begin
      stage_random_list(6, MIX_FULL);
      send_staged_list();
    end
    tx_gaps_on = 1'b1;
  endtask

  task automatic test_random_lists();
    int         sent_here;
    int         list_index;
    int         len;
    int         r;
    value_mix_t mix;
    sent_here  = 0;
    list_index = 0;
    while (sent_here < 110) begin
      r = $urandom_range(0, 99);
      if (r < 70)      len = $urandom_range(1, 6);
      else if (r < 90) len = $urandom_range(7, 16);
      else if (r < 97) len = $urandom_range(17, SORT_DEPTH);
      else             len = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 3);
      r = $urandom_range(0, 9);
      mix = (r < 5) ? MIX_FULL : (r < 8) ? MIX_NARROW : MIX_EDGE;
      tx_gaps_on   = !(list_index >= 6 && list_index < 10);
      rx_stalls_on = !(list_index >= 6 && list_index < 10);
      stage_random_list(len, mix);
      send_staged_list();
      sent_here += len;
      list_index++;
    end
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin : result_sink
    int   stall_left;
    logic ready_next;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        ready_next = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        ready_next = 1'b0;
      end else begin
        ready_next = 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
      result_ready <= ready_next;
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
          $display("%0t: unexpected result value %0d last %0b overflow %0b", $realtime,
                   result.value_res, result.last_res, result.overflow);
        end
      end else begin
        want = expected_results.pop_front();
        if (result.value_res !== want.value_res || result.last_res !== want.last_res ||
            result.overflow !== want.overflow) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS) begin
            $display("%0t: mismatch: expected value %0d last %0b overflow %0b, got value %0d last %0b overflow %0b",
                     $realtime, want.value_res, want.last_res, want.overflow,
                     result.value_res, result.last_res, result.overflow);
          end
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Run did not complete in time.");
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int waited;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_element();
    test_extreme_values();
    test_equal_values();
    test_full_store();
    test_overflow();
    test_backpressure();
    test_random_lists();

    @(negedge clk);
    item_valid <= 1'b0;

    waited = 0;
    while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0d expected results never arrived.", expected_results.size());
      fail_count += expected_results.size();
    end

    $display("Sent %0d requests in %0d lists, the longest holding %0d elements.",
             requests_sent, lists_closed, longest_list);
    $display("%0d lists lost elements to a full store; %0d results were checked.",
             overflow_lists, results_seen);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures in total.", fail_count);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
